FILE: src/bcde_pkg.sv
// Package for the binary code distance estimator: shared types, constants and code helpers.
// No dependencies; every other file of the block but bcde_if imports it.
package bcde_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int QUEUE_DEPTH     = 2;

    localparam int ACC_W  = 64;
    localparam int CODE_W = 9;
    localparam int PROD_W = 42;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic [16:0]        ONE_Q16 = 17'd65536;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_METRIC   = 2'd0,
        CFG_BITS     = 2'd1,
        CFG_CLUSTERS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        metric_ip;
        logic [3:0]  bits_total;
        logic [16:0] trained_clusters;
    } t_cfg;

    // One finished record as handed from the front to the back.
    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic               fine;
        logic signed [31:0] query_sum;
        logic signed [31:0] centroid_add;
        logic signed [31:0] centroid_error;
        logic signed [31:0] record_add;
        logic signed [31:0] record_scale;
        logic signed [31:0] record_error;
        logic [15:0]        cluster_id;
    } t_fin;

    // Bit count clamped to the meaningful range of one to nine.
    function automatic logic [3:0] eff_bits(input logic [3:0] b);
        logic [3:0] r;
        if (b == 4'd0) begin
            r = 4'd1;
        end else if (b > 4'd9) begin
            r = 4'd9;
        end else begin
            r = b;
        end
        return r;
    endfunction

    // Per-dimension code: the sign alone, or the sign above the low extra bits.
    function automatic logic [CODE_W-1:0] code_of(input logic sgn, input logic [7:0] extra,
                                                 input logic fine, input logic [3:0] b);
        logic [3:0]        sh;
        logic [CODE_W-1:0] mask;
        logic [CODE_W-1:0] r;
        sh   = b - 4'd1;
        mask = (CODE_W'(1) << sh) - CODE_W'(1);
        if (fine) begin
            r = (CODE_W'(sgn) << sh) | ({1'b0, extra} & mask);
        end else begin
            r = CODE_W'(sgn);
        end
        return r;
    endfunction

endpackage

FILE: src/bcde_if.sv
// Channel interfaces of the binary code distance estimator: input words, result words, config.
// Depends on nothing; valid/ready handshake, a word moves when both are high.
interface bcde_in_if;
    logic               valid;
    logic               ready;
    logic               sign_bit;
    logic [7:0]         extra_code;
    logic signed [31:0] query_value;
    logic               fine_mode;
    logic               last;
    logic signed [31:0] query_sum;
    logic [15:0]        cluster_id;
    logic signed [31:0] centroid_add;
    logic signed [31:0] centroid_error;
    logic signed [31:0] record_add;
    logic signed [31:0] record_scale;
    logic signed [31:0] record_error;

    modport source (
        output valid, sign_bit, extra_code, query_value, fine_mode, last, query_sum,
               cluster_id, centroid_add, centroid_error, record_add, record_scale,
               record_error,
        input  ready
    );
    modport sink (
        input  valid, sign_bit, extra_code, query_value, fine_mode, last, query_sum,
               cluster_id, centroid_add, centroid_error, record_add, record_scale,
               record_error,
        output ready
    );
endinterface

interface bcde_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] score;
    logic signed [31:0] lower_bound;
    logic               invalid_cluster;

    modport source (output valid, score, lower_bound, invalid_cluster, input ready);
    modport sink (input valid, score, lower_bound, invalid_cluster, output ready);
endinterface

interface bcde_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/bcde_front.sv
// Front end: accepts dimension words, forms code times query value and accumulates per record.
// Depends on bcde_pkg and bcde_in_if; pushes finished records into the record queue.
module bcde_front
    import bcde_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcde_in_if.sink   i_in,
    input  t_cfg      i_cfg,
    output logic      o_push,
    output t_fin      o_push_data,
    input  logic      i_q_full
);

    localparam int CNT_W = $clog2(MAX_DIMENSION + 1);

    logic [CNT_W-1:0]        r_cnt;
    logic                    r_a_valid;
    logic                    r_a_add;
    logic                    r_a_last;
    logic signed [PROD_W-1:0] r_prod;
    t_fin                    r_a_fin;
    logic [ACC_W-1:0]        r_acc;

    logic                    advance;
    logic                    accept;
    logic                    cnt_room;
    logic [CODE_W-1:0]       code;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]        acc_sum;

    assign advance  = r_a_valid && !(r_a_last && i_q_full);
    assign i_in.ready = !r_a_valid || advance;
    assign accept   = i_in.valid && i_in.ready;
    assign cnt_room = r_cnt < CNT_W'(MAX_DIMENSION);

    assign code = code_of(i_in.sign_bit, i_in.extra_code, i_in.fine_mode,
                          eff_bits(i_cfg.bits_total));
    assign prod = $signed({1'b0, code}) * i_in.query_value;

    assign acc_sum = r_acc + (r_a_add ? {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod}
                                      : {ACC_W{1'b0}});

    assign o_push = r_a_valid && r_a_last && !i_q_full;
    always_comb begin
        o_push_data     = r_a_fin;
        o_push_data.acc = acc_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_cnt     <= '0;
            r_acc     <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                if (i_in.last) begin
                    r_cnt <= '0;
                end else if (cnt_room) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            if (advance) begin
                r_acc <= r_a_last ? {ACC_W{1'b0}} : acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_add                <= cnt_room;
            r_a_last               <= i_in.last;
            r_prod                 <= prod;
            r_a_fin.acc            <= '0;
            r_a_fin.fine           <= i_in.fine_mode;
            r_a_fin.query_sum      <= i_in.query_sum;
            r_a_fin.centroid_add   <= i_in.centroid_add;
            r_a_fin.centroid_error <= i_in.centroid_error;
            r_a_fin.record_add     <= i_in.record_add;
            r_a_fin.record_scale   <= i_in.record_scale;
            r_a_fin.record_error   <= i_in.record_error;
            r_a_fin.cluster_id     <= i_in.cluster_id;
        end
    end

endmodule

FILE: src/bcde_fifo.sv
// Short record queue between the front end and the finishing sequencer.
// Depends on bcde_pkg for the record type.
module bcde_fifo
    import bcde_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_fin i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_fin o_pop_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_fin             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_empty    = r_count == '0;
    assign o_pop_data = r_mem[r_rp];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= wrap_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

FILE: src/bcde_back.sv
// Finishing sequencer: turns a queued record into score, lower bound and cluster flag.
// Depends on bcde_pkg and bcde_out_if; one shared 32x32 multiplier serves the error and scale products.
module bcde_back
    import bcde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_empty,
    input  t_fin       i_q_data,
    output logic       o_pop,
    bcde_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_MID, S_D, S_MAG, S_P1, S_P2, S_M, S_SUM, S_LOW, S_OUT
    } t_state;

    t_state r_state;

    logic [ACC_W-1:0]   r_acc;
    logic               r_fine;
    logic signed [31:0] r_qs;
    logic signed [31:0] r_ra;
    logic signed [31:0] r_ca;
    logic [31:0]        r_sm;
    logic               r_sneg;
    logic [31:0]        r_rem;
    logic [31:0]        r_cem;
    logic               r_eneg;
    logic               r_inv;
    logic signed [42:0] r_mq;
    logic [63:0]        r_d2;
    logic [63:0]        r_dm;
    logic               r_dneg;
    logic [63:0]        r_em;
    logic [63:0]        r_p1;
    logic [63:0]        r_p2;
    logic signed [41:0] r_sdot;
    logic signed [47:0] r_err;
    logic signed [42:0] r_score;
    logic signed [49:0] r_lower;
    logic               r_ovalid;
    logic signed [31:0] r_oscore;
    logic signed [31:0] r_olower;
    logic               r_oinv;

    logic [3:0]         b;
    logic [9:0]         mid2;
    logic signed [42:0] mq;
    logic [63:0]        d2;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        m_sum;
    logic [46:0]        m_raw;
    logic [40:0]        m_c;
    logic [41:0]        sd_u;
    logic [4:0]         sh;
    logic [63:0]        e_sum;
    logic [63:0]        e_shift;
    logic [47:0]        e_u;
    logic signed [42:0] score_n;
    logic signed [49:0] lower_n;
    logic               load_out;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (!v[49] && (|v[48:31])) begin
            r = SAT_MAX;
        end else if (v[49] && !(&v[48:31])) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign b     = eff_bits(i_cfg.bits_total);
    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    // Twice the midpoint: 1 in coarse mode, 2^bits - 1 in fine mode.
    assign mid2 = r_fine ? ((10'd1 << b) - 10'd1) : 10'd1;
    assign mq   = $signed({1'b0, mid2}) * r_qs;
    assign d2   = {r_acc[62:0], 1'b0} - {{21{r_mq[42]}}, r_mq};

    always_comb begin
        unique case (r_state)
            S_P1: begin
                mul_a = r_sm;
                mul_b = r_dm[31:0];
            end
            S_P2: begin
                mul_a = r_sm;
                mul_b = r_dm[63:32];
            end
            default: begin
                mul_a = r_rem;
                mul_b = r_cem;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Scaled dot product, rounded at bit 17 and clamped to 2^40 in magnitude.
    assign m_sum = {r_p2[31:0], 32'd0} + r_p1 + 64'h1_0000;
    assign m_raw = m_sum[63:17];
    assign m_c   = ((|r_p2[63:25]) || (m_raw > 47'(41'd1 << 40))) ? (41'd1 << 40)
                                                                  : m_raw[40:0];
    assign sd_u  = {1'b0, m_c};

    // Error term shifted right by 16 plus the extra bits in fine mode, rounded.
    assign sh      = 5'd16 + (r_fine ? ({1'b0, b} - 5'd1) : 5'd0);
    assign e_sum   = r_em + (64'd1 << (sh - 5'd1));
    assign e_shift = e_sum >> sh;
    assign e_u     = {1'b0, e_shift[46:0]};

    assign score_n = {{11{r_ra[31]}}, r_ra} + {{11{r_ca[31]}}, r_ca}
                   + {r_sdot[41], r_sdot}
                   - (i_cfg.metric_ip ? 43'($unsigned(ONE_Q16)) : 43'd0);
    assign lower_n = {{7{r_score[42]}}, r_score} - {{2{r_err[47]}}, r_err};

    assign load_out = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ({1'b0, i_q_data.cluster_id} >= i_cfg.trained_clusters)
                                   ? S_OUT : S_MID;
                    end
                end
                S_MID: r_state <= S_D;
                S_D:   r_state <= S_MAG;
                S_MAG: r_state <= S_P1;
                S_P1:  r_state <= S_P2;
                S_P2:  r_state <= S_M;
                S_M:   r_state <= S_SUM;
                S_SUM: r_state <= S_LOW;
                S_LOW: r_state <= S_OUT;
                S_OUT: begin
                    if (load_out) begin
                        r_ovalid <= 1'b1;
                        r_oinv   <= r_inv;
                        r_oscore <= r_inv ? SAT_MAX : sat32({{7{r_score[42]}}, r_score});
                        r_olower <= r_inv ? SAT_MAX : sat32(r_lower);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc  <= i_q_data.acc;
            r_fine <= i_q_data.fine;
            r_qs   <= i_q_data.query_sum;
            r_ra   <= i_q_data.record_add;
            r_ca   <= i_q_data.centroid_add;
            r_sm   <= abs32(i_q_data.record_scale);
            r_sneg <= i_q_data.record_scale[31];
            r_rem  <= abs32(i_q_data.record_error);
            r_cem  <= abs32(i_q_data.centroid_error);
            r_eneg <= i_q_data.record_error[31] ^ i_q_data.centroid_error[31];
            r_inv  <= {1'b0, i_q_data.cluster_id} >= i_cfg.trained_clusters;
        end
        case (r_state)
            S_MID: r_mq <= mq;
            S_D: begin
                r_d2 <= d2;
                r_em <= mul_p;
            end
            S_MAG: begin
                r_dm   <= r_d2[63] ? (~r_d2 + 64'd1) : r_d2;
                r_dneg <= r_d2[63];
            end
            S_P1: r_p1 <= mul_p;
            S_P2: r_p2 <= mul_p;
            S_M: begin
                r_sdot <= (r_sneg ^ r_dneg) ? $signed(~sd_u + 42'd1) : $signed(sd_u);
                r_err  <= r_eneg ? $signed(~e_u + 48'd1) : $signed(e_u);
            end
            S_SUM: r_score <= score_n;
            S_LOW: r_lower <= lower_n;
            default: ;
        endcase
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.score           = r_oscore;
    assign o_out.lower_bound     = r_olower;
    assign o_out.invalid_cluster = r_oinv;

endmodule

FILE: src/binary_code_distance_estimator_top.sv
// Top level of the binary code distance estimator: config registers, front end, queue, back end.
// Depends on bcde_pkg, bcde_if, bcde_front, bcde_fifo and bcde_back.
//
//   Channel  Direction  Word carries
//   i_in     in         one dimension: sign bit, extra code, query value, mode, last,
//                       and the finishing fields read on the last word of a record
//   o_out    out        one result per record: score, lower bound, invalid cluster flag
//   i_cfg    in         register write: index (0 metric, 1 bits, 2 clusters) and data
//
// The front end takes one dimension word per cycle while it has room. The finishing sequencer
// works on one record at a time, around its single shared 32x32 multiplier and the add chain
// that follows it, and takes no new record until the last one has been loaded to the output.
// A two-entry record queue lets the front keep accepting while a result waits on o_out. Reset
// is synchronous, active low, and leaves the registers at metric 0, seven bits, zero trained
// clusters.
module binary_code_distance_estimator_top
    import bcde_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcde_in_if.sink    i_in,
    bcde_out_if.source o_out,
    bcde_cfg_if.sink   i_cfg
);

    // Configuration registers. Writes are always taken; the user must change the register set only
    // while no record is in flight; the block does not enforce this. The datapath reads it directly.
    t_cfg r_cfg;

    // Record queue signals between the two halves.
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_fin q_wdata;
    t_fin q_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.metric_ip        <= 1'b0;
            r_cfg.bits_total       <= 4'd7;
            r_cfg.trained_clusters <= 17'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_METRIC:   r_cfg.metric_ip        <= i_cfg.data[0];
                CFG_BITS:     r_cfg.bits_total       <= i_cfg.data[3:0];
                CFG_CLUSTERS: r_cfg.trained_clusters <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Front end: code times query value into the 64-bit accumulator, one word per cycle while it has room.
    bcde_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_push      (q_push),
        .o_push_data (q_wdata),
        .i_q_full    (q_full)
    );

    // Finished records wait here until the sequencer is free.
    bcde_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wdata),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_rdata),
        .o_empty     (q_empty)
    );

    // Back end: midpoint correction, scaling, error bound, saturation and the output register.
    bcde_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: verif/binary_code_distance_estimator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_code_distance_estimator_top: directed table, then random records.
// Depends on bcde_pkg, bcde_if and the estimator RTL; results are scored by a local model.
module binary_code_distance_estimator_top_tb;
    import bcde_pkg::*;

    localparam int DIM_LIMIT       = MAX_DIM_DEFAULT;
    // Margin for the finishing sequencer, whose record queue holds two more records.
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 3000;
    // Index 3 has no register behind it; a write to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Fields that only matter on the word that closes a record.
    typedef struct packed {
        logic signed [31:0] qsum;
        logic [15:0]        cid;
        logic signed [31:0] cadd;
        logic signed [31:0] cerr;
        logic signed [31:0] radd;
        logic signed [31:0] rscale;
        logic signed [31:0] rerr;
    } finish_t;

    // One dimension word as it goes onto the input channel.
    typedef struct packed {
        logic               sign_bit;
        logic [7:0]         extra;
        logic signed [31:0] qv;
        logic               fine;
        logic               last;
        finish_t            f;
    } dim_word_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic signed [31:0] lower;
        logic               invalid;
    } score_word_t;

    typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

    // One line of the directed table: either a register write or a dimension word. A word
    // row may carry a hand-written result, which then replaces the modeled one.
    typedef struct {
        row_kind_e   kind;
        logic [1:0]  idx;
        logic [16:0] data;
        dim_word_t   w;
        bit          typed;
        score_word_t res;
    } row_t;

    logic clk;
    logic rst_n;

    bcde_in_if  in_bus();
    bcde_out_if out_bus();
    bcde_cfg_if cfg_bus();

    binary_code_distance_estimator_top #(
        .MAX_DIMENSION(DIM_LIMIT)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    // Local copy of the register file and the running dot product of the open record.
    logic        est_metric_ip;
    logic [3:0]  est_bits;
    logic [16:0] est_clusters;
    logic [63:0] dot_sum;
    int unsigned dims_in_record;

    score_word_t pending_scores[$];

    int send_pct;
    int recv_pct;
    int n_fail;
    int n_words;
    int n_records;
    int n_invalid;
    int n_writes;
    int n_results;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > longint'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (v < longint'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    // Adds one dimension to the open record. On the closing word the record is scored:
    // returns 1 and fills r, and the running sum starts over.
    function automatic bit advance_estimate(input dim_word_t w, output score_word_t r);
        logic [3:0]   b;
        logic [8:0]   mask;
        logic [8:0]   code;
        logic [63:0]  acc_now;
        logic [63:0]  d2;
        logic [63:0]  smag;
        logic [63:0]  dmag;
        logic [127:0] prod;
        logic [127:0] mag;
        logic [63:0]  emag;
        logic [63:0]  e;
        longint       mid2;
        longint       sd;
        longint       score;
        longint       ep;
        longint       err;
        bit           sneg;
        int           sh;
        r = '0;
        b = (est_bits == 4'd0) ? 4'd1 : (est_bits > 4'd9) ? 4'd9 : est_bits;
        mask = (9'd1 << (b - 4'd1)) - 9'd1;
        if (w.fine) begin
            code = (9'(w.sign_bit) << (b - 4'd1)) | ({1'b0, w.extra} & mask);
        end else begin
            code = 9'(w.sign_bit);
        end
        // Words past the dimension limit still count as record ends but add nothing.
        if (dims_in_record < DIM_LIMIT) begin
            dot_sum = dot_sum + 64'(longint'(code) * longint'(w.qv));
            dims_in_record++;
        end
        if (!w.last) begin
            return 1'b0;
        end
        acc_now        = dot_sum;
        dot_sum        = '0;
        dims_in_record = 0;
        if ({1'b0, w.f.cid} >= est_clusters) begin
            r.score   = SAT_MAX;
            r.lower   = SAT_MAX;
            r.invalid = 1'b1;
            return 1'b1;
        end
        // Twice the midpoint, so that the correction stays an integer.
        if (w.fine) begin
            mid2 = (longint'(1) << b) - 1;
        end else begin
            mid2 = 1;
        end
        d2   = (acc_now << 1) - 64'(mid2 * longint'(w.f.qsum));
        sneg = w.f.rscale < 0;
        smag = sneg ? 64'(-longint'(w.f.rscale)) : 64'(longint'(w.f.rscale));
        dmag = d2[63] ? (~d2 + 64'd1) : d2;
        prod = {64'd0, smag} * {64'd0, dmag};
        mag  = (prod + 128'd65536) >> 17;
        if (mag > (128'd1 << 40)) begin
            mag = 128'd1 << 40;
        end
        sd = longint'(mag[63:0]);
        if (sneg != d2[63]) begin
            sd = -sd;
        end
        score = longint'(w.f.radd) + longint'(w.f.cadd) + sd;
        if (est_metric_ip) begin
            score = score - 65536;
        end
        ep   = longint'(w.f.rerr) * longint'(w.f.cerr);
        emag = (ep < 0) ? 64'(-ep) : 64'(ep);
        sh   = 16 + (w.fine ? int'(b) - 1 : 0);
        e    = (emag + (64'd1 << (sh - 1))) >> sh;
        err  = (ep < 0) ? -longint'(e) : longint'(e);
        r.score   = clip32(score);
        r.lower   = clip32(score - err);
        r.invalid = 1'b0;
        return 1'b1;
    endfunction

    // Q16.16 value: mostly moderate magnitudes so scores stay in range, with some full-range
    // words and some corner values.
    function automatic logic signed [31:0] rand_q16();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = SAT_MAX;
                    1:       v = SAT_MIN;
                    2:       v = 32'sd0;
                    3:       v = 32'sd1;
                    4:       v = -32'sd1;
                    default: v = 32'sh0001_0000;
                endcase
            end
            1, 2: v = $urandom;
            default: begin
                v = $urandom_range(0, 1 << $urandom_range(4, 22));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic finish_t rand_finish();
        finish_t f;
        int      hi;
        f.qsum   = rand_q16();
        f.cadd   = rand_q16();
        f.cerr   = rand_q16();
        f.radd   = rand_q16();
        f.rscale = rand_q16();
        f.rerr   = rand_q16();
        // Keep most cluster ids trained so that real scores dominate.
        if (est_clusters != 17'd0 && $urandom_range(0, 99) < 85) begin
            hi    = (est_clusters > 17'd65536) ? 65535 : int'(est_clusters) - 1;
            f.cid = $urandom_range(0, hi);
        end else begin
            f.cid = $urandom;
        end
        return f;
    endfunction

    function automatic finish_t fin(input logic signed [31:0] qsum, input logic [15:0] cid,
                                    input logic signed [31:0] cadd, input logic signed [31:0] cerr,
                                    input logic signed [31:0] radd,
                                    input logic signed [31:0] rscale,
                                    input logic signed [31:0] rerr);
        finish_t f;
        f.qsum   = qsum;
        f.cid    = cid;
        f.cadd   = cadd;
        f.cerr   = cerr;
        f.radd   = radd;
        f.rscale = rscale;
        f.rerr   = rerr;
        return f;
    endfunction

    function automatic row_t word_row(input logic sgn, input logic [7:0] extra,
                                      input logic signed [31:0] qv, input logic fine,
                                      input logic last, input finish_t f);
        row_t r;
        r.kind       = ROW_WORD;
        r.idx        = '0;
        r.data       = '0;
        r.w.sign_bit = sgn;
        r.w.extra    = extra;
        r.w.qv       = qv;
        r.w.fine     = fine;
        r.w.last     = last;
        r.w.f        = f;
        r.typed      = 1'b0;
        r.res        = '0;
        return r;
    endfunction

    function automatic row_t with_result(input row_t r, input logic signed [31:0] score,
                                         input logic signed [31:0] lower, input logic inv);
        row_t t;
        t             = r;
        t.typed       = 1'b1;
        t.res.score   = score;
        t.res.lower   = lower;
        t.res.invalid = inv;
        return t;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [16:0] data);
        row_t r;
        r      = word_row(1'b0, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Presents one word, holding valid across back-to-back words, and records the result
    // that the word is due to produce once it has been taken.
    task automatic send_word(input dim_word_t w, input bit typed, input score_word_t typed_res);
        score_word_t r;
        bit          has;
        if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
            in_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
        end
        in_bus.valid          <= 1'b1;
        in_bus.sign_bit       <= w.sign_bit;
        in_bus.extra_code     <= w.extra;
        in_bus.query_value    <= w.qv;
        in_bus.fine_mode      <= w.fine;
        in_bus.last           <= w.last;
        in_bus.query_sum      <= w.f.qsum;
        in_bus.cluster_id     <= w.f.cid;
        in_bus.centroid_add   <= w.f.cadd;
        in_bus.centroid_error <= w.f.cerr;
        in_bus.record_add     <= w.f.radd;
        in_bus.record_scale   <= w.f.rscale;
        in_bus.record_error   <= w.f.rerr;
        do @(posedge clk); while (in_bus.ready !== 1'b1);
        n_words++;
        has = advance_estimate(w, r);
        if (has) begin
            if (typed) begin
                r = typed_res;
            end
            pending_scores.push_back(r);
            n_records++;
            if (r.invalid) begin
                n_invalid++;
            end
        end
    endtask

    task automatic send_record(input int len, input bit mixed);
        dim_word_t w;
        bit        rec_fine;
        rec_fine = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            w.sign_bit = $urandom_range(0, 1);
            w.extra    = $urandom_range(0, 255);
            w.qv       = rand_q16();
            w.fine     = mixed ? 1'($urandom_range(0, 1)) : rec_fine;
            w.last     = (i == len - 1);
            // Finishing fields are noise on every word but the last.
            w.f        = rand_finish();
            send_word(w, 1'b0, '0);
        end
    endtask

    // A register write. With hold set, valid stays high for a write that follows at once.
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data, input bit hold);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_METRIC:   est_metric_ip = data[0];
            CFG_BITS:     est_bits = data[3:0];
            CFG_CLUSTERS: est_clusters = data;
            default: ;
        endcase
        n_writes++;
        if (!hold) begin
            cfg_bus.valid <= 1'b0;
        end
    endtask

    // Stops the input stream and lets every outstanding record come out, plus a margin for
    // the finishing sequencer, so that registers can change safely.
    task automatic wait_until_quiet();
        in_bus.valid <= 1'b0;
        while (pending_scores.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: checks each taken word against the oldest expectation and then decides
    // whether to stall on the next cycle.
    initial begin
        score_word_t want;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                n_results++;
                if (pending_scores.size() == 0) begin
                    $error("result word with no record pending: score %0d lower %0d",
                           out_bus.score, out_bus.lower_bound);
                    n_fail++;
                end else begin
                    want = pending_scores.pop_front();
                    if (out_bus.score !== want.score) begin
                        $error("score: expected %0d, got %0d", want.score, out_bus.score);
                        n_fail++;
                    end
                    if (out_bus.lower_bound !== want.lower) begin
                        $error("lower_bound: expected %0d, got %0d", want.lower,
                               out_bus.lower_bound);
                        n_fail++;
                    end
                    if (out_bus.invalid_cluster !== want.invalid) begin
                        $error("invalid_cluster: expected %0d, got %0d", want.invalid,
                               out_bus.invalid_cluster);
                        n_fail++;
                    end
                end
            end
            out_bus.ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    // Watchdog: any cycle in which no channel moves a word counts toward the limit.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
                (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        row_t        script[$];
        finish_t     f0;
        logic [3:0]  n_bits;
        logic [16:0] clusters;
        logic [16:0] rnd17;
        logic        metric;
        int          setting;
        int          budget;
        int          pick;
        int          len;

        // Every input starts known; reset is held at the start and never again.
        rst_n                 <= 1'b0;
        in_bus.valid          <= 1'b0;
        in_bus.sign_bit       <= 1'b0;
        in_bus.extra_code     <= '0;
        in_bus.query_value    <= '0;
        in_bus.fine_mode      <= 1'b0;
        in_bus.last           <= 1'b0;
        in_bus.query_sum      <= '0;
        in_bus.cluster_id     <= '0;
        in_bus.centroid_add   <= '0;
        in_bus.centroid_error <= '0;
        in_bus.record_add     <= '0;
        in_bus.record_scale   <= '0;
        in_bus.record_error   <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= '0;
        cfg_bus.data          <= '0;

        est_metric_ip  = 1'b0;
        est_bits       = 4'd7;
        est_clusters   = 17'd0;
        dot_sum        = '0;
        dims_in_record = 0;
        n_fail         = 0;
        n_words        = 0;
        n_records      = 0;
        n_invalid      = 0;
        n_writes       = 0;
        n_results      = 0;
        send_pct       = 31;
        recv_pct       = 86;

        f0 = '0;

        // With no cluster trained after reset, even id zero is out of range.
        script.push_back(with_result(word_row(1'b1, 8'hFF, 32'sh0001_0000, 1'b1, 1'b1, f0),
                                     SAT_MAX, SAT_MAX, 1'b1));
        // All ids valid, inner product on, nine bits; unused data bits are set on purpose.
        script.push_back(cfg_row(CFG_CLUSTERS, 17'h1_0000));
        script.push_back(cfg_row(CFG_METRIC, 17'h1_FFFF));
        script.push_back(cfg_row(CFG_BITS, 17'h1_FFF9));
        script.push_back(cfg_row(CFG_SPARE, 17'h0_0005));
        // Largest codes against both query extremes, every finishing field at an extreme.
        script.push_back(word_row(1'b1, 8'hFF, SAT_MAX, 1'b1, 1'b0, f0));
        script.push_back(word_row(1'b1, 8'hFF, SAT_MIN, 1'b1, 1'b1,
                                  fin(SAT_MAX, 16'hFFFF, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX,
                                      SAT_MIN)));
        // Zero record: only the inner product offset of minus one remains.
        script.push_back(with_result(word_row(1'b0, 8'h00, 32'sd0, 1'b0, 1'b1,
                                              fin(32'sd0, 16'd0, 32'sd0, SAT_MAX, 32'sd0,
                                                  SAT_MAX, 32'sd0)),
                                     32'shFFFF_0000, 32'shFFFF_0000, 1'b0));
        // Additive terms alone drive the score to each saturation limit.
        script.push_back(with_result(word_row(1'b1, 8'hFF, 32'sd0, 1'b0, 1'b1,
                                              fin(32'sd0, 16'd1, SAT_MIN, 32'sd0, SAT_MIN,
                                                  32'sd0, 32'sd0)),
                                     SAT_MIN, SAT_MIN, 1'b0));
        script.push_back(with_result(word_row(1'b0, 8'h00, SAT_MAX, 1'b0, 1'b1,
                                              fin(32'sd0, 16'd2, SAT_MAX, SAT_MAX, SAT_MAX,
                                                  SAT_MAX, 32'sd0)),
                                     SAT_MAX, SAT_MAX, 1'b0));
        // Bit count zero behaves as one bit: fine mode falls back to the sign alone.
        script.push_back(cfg_row(CFG_BITS, 17'h0_0000));
        script.push_back(cfg_row(CFG_METRIC, 17'h0_0000));
        script.push_back(word_row(1'b1, 8'hFF, 32'sh0001_0000, 1'b1, 1'b1,
                                  fin(32'sh0001_0000, 16'd3, 32'sh0000_8000, 32'sh0002_0000,
                                      32'sh0001_0000, 32'sh0001_0000, 32'sh0000_4000)));
        // Bit count above nine is treated as nine.
        script.push_back(cfg_row(CFG_BITS, 17'h0_000F));
        script.push_back(word_row(1'b0, 8'hA5, 32'sh0003_2000, 1'b1, 1'b0, f0));
        script.push_back(word_row(1'b1, 8'h5A, 32'shFFFE_8000, 1'b1, 1'b1,
                                  fin(32'sh0001_8000, 16'd7, -32'sh0000_4000, 32'sh0003_0000,
                                      32'sh0000_2000, -32'sh0000_C000, 32'sh0001_1000)));
        // Cluster id just below, at, and far above the trained count.
        script.push_back(cfg_row(CFG_CLUSTERS, 17'd100));
        script.push_back(word_row(1'b1, 8'h3C, 32'sh0000_C000, 1'b0, 1'b1,
                                  fin(32'sh0000_4000, 16'd99, 32'sh0000_1000, 32'sh0000_8000,
                                      32'sh0000_2000, 32'sh0002_0000, 32'sh0000_8000)));
        script.push_back(with_result(word_row(1'b1, 8'h3C, 32'sh0000_C000, 1'b0, 1'b1,
                                              fin(32'sd0, 16'd100, 32'sd0, 32'sd0, 32'sd0,
                                                  32'sd0, 32'sd0)),
                                     SAT_MAX, SAT_MAX, 1'b1));
        script.push_back(with_result(word_row(1'b0, 8'h00, 32'sd0, 1'b1, 1'b1,
                                              fin(32'sd0, 16'hFFFF, 32'sd0, 32'sd0, 32'sd0,
                                                  32'sd0, 32'sd0)),
                                     SAT_MAX, SAT_MAX, 1'b1));
        // Modes switch inside one record; the closing word is coarse and picks the midpoint.
        script.push_back(word_row(1'b1, 8'h81, 32'sh0002_0000, 1'b0, 1'b0, f0));
        script.push_back(word_row(1'b1, 8'h7E, -32'sh0001_0000, 1'b1, 1'b0, f0));
        script.push_back(word_row(1'b0, 8'hC3, 32'sh0000_8000, 1'b0, 1'b1,
                                  fin(32'sh0001_0000, 16'd50, 32'sd0, 32'sh0001_0000,
                                      32'sh0000_1000, 32'sh0001_0000, 32'sh0000_0100)));
        // Huge dot product times the largest scale hits the product clamp.
        script.push_back(word_row(1'b1, 8'hFF, SAT_MAX, 1'b1, 1'b0, f0));
        script.push_back(word_row(1'b1, 8'hFF, SAT_MAX, 1'b1, 1'b0, f0));
        script.push_back(word_row(1'b1, 8'hFF, SAT_MAX, 1'b1, 1'b1,
                                  fin(SAT_MIN, 16'd1, 32'sd0, 32'sd0, 32'sd0, SAT_MAX,
                                      32'sd0)));
        // Error terms that land exactly on a rounding half, positive and negative.
        script.push_back(word_row(1'b0, 8'h00, 32'sd0, 1'b0, 1'b1,
                                  fin(32'sd0, 16'd5, 32'sd0, 32'sh0000_8000, 32'sd0, 32'sd0,
                                      32'sd1)));
        script.push_back(word_row(1'b0, 8'h00, 32'sd0, 1'b1, 1'b1,
                                  fin(32'sd0, 16'd6, 32'sd0, 32'sh0080_0000, 32'sd0, 32'sd0,
                                      -32'sd1)));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Consecutive register rows share one held valid.
        for (int i = 0; i < script.size(); i++) begin
            if (script[i].kind == ROW_CFG) begin
                if (i == 0 || script[i - 1].kind == ROW_WORD) begin
                    wait_until_quiet();
                end
                write_reg(script[i].idx, script[i].data,
                          i + 1 < script.size() && script[i + 1].kind == ROW_CFG);
            end else begin
                send_word(script[i].w, script[i].typed, script[i].res);
            end
        end

        // Random part: three pressure phases, four register settings in each. The early
        // settings hit the register extremes, later ones are random.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_pct = 31;
                    recv_pct = 86;
                end
                1: begin
                    send_pct = 86;
                    recv_pct = 31;
                end
                default: begin
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                setting = phase * 4 + k;
                case (setting)
                    0:       n_bits = 4'd1;
                    1:       n_bits = 4'd9;
                    2:       n_bits = 4'd0;
                    3:       n_bits = 4'd15;
                    default: n_bits = $urandom_range(0, 15);
                endcase
                case (setting)
                    0, 6:    clusters = 17'h1_0000;
                    1:       clusters = 17'd1;
                    5:       clusters = 17'd0;
                    9:       clusters = 17'h1_FFFF;
                    default: clusters = $urandom_range(1, 65536);
                endcase
                metric = (setting < 4) ? 1'(setting) : 1'($urandom_range(0, 1));
                wait_until_quiet();
                rnd17 = 17'($urandom);
                write_reg(CFG_METRIC, {rnd17[16:1], metric}, 1'b1);
                write_reg(CFG_BITS, {rnd17[16:4], n_bits}, 1'b1);
                write_reg(CFG_CLUSTERS, clusters, 1'b0);
                budget = n_words + 108;
                while (n_words < budget) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        len = $urandom_range(1, 6);
                    end else if (pick < 97) begin
                        len = $urandom_range(7, 32);
                    end else begin
                        len = $urandom_range(33, 150);
                    end
                    send_record(len, $urandom_range(0, 9) == 0);
                end
                // One record that runs past the dimension limit, at full rate.
                if (setting == 11) begin
                    send_record(DIM_LIMIT + 3, 1'b0);
                end
            end
        end

        wait_until_quiet();
        $display("Covered %0d dimension words in %0d scored records (%0d invalid cluster)",
                 n_words, n_records, n_invalid);
        $display("with %0d register writes across three sender/receiver stall mixes.",
                 n_writes);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/bcde_pkg.sv
src/bcde_if.sv
src/bcde_front.sv
src/bcde_fifo.sv
src/bcde_back.sv
src/binary_code_distance_estimator_top.sv
verif/binary_code_distance_estimator_top_tb.sv
